/* sv/set_assoc_cache_tag_controller_unit_macros.svh */
// assertion macros for the set-associative cache tag controller
// no dependencies; included by modules that assert
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SACT_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define SACT_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define SACT_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define SACT_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

/* sv/sact_pkg.sv */
// shared types and constants of the cache tag controller
// no dependencies
`default_nettype none
package sact_pkg;
	localparam int MAX_WAYS_D   = 8;
	localparam int MAX_SETS_D   = 1024;
	localparam int LINE_BYTES_D = 64;
	localparam int ADDR_WIDTH_D = 48;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 4;
	localparam int CNT_W        = 32;

	localparam logic [CFG_IDX_W-1:0] REG_SET_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAYS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE    = 2'd3;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

/* sv/sact_if.sv */
// valid/ready channel interface with generic payload
// depends on nothing
`default_nettype none
interface sact_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/sact_ram.sv */
// generic single-port synchronous ram, registered read
// no dependencies
`default_nettype none
module sact_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

/* sv/set_assoc_cache_tag_controller_unit.sv */
// top level of the set-associative cache tag controller
// depends on sact_pkg, sact_ram and the assertion macro header
//
// channel  dir  payload
// req      in   func, address
// rsp      out  hit, memory_read, memory_write, four running totals
// cfg      in   we, idx, wdata (plain write port)
//
// an access reads its set from the row memory, compares and decides while the
// row is written back, then loads the result register
// after reset a clearing pass sweeps MAX_SETS rows, one a cycle, before
// the first request is taken
// a pending result holds until taken; no new request enters meanwhile
`default_nettype none
`include "set_assoc_cache_tag_controller_unit_macros.svh"
module set_assoc_cache_tag_controller_unit #(
	parameter int MAX_WAYS   = sact_pkg::MAX_WAYS_D,
	parameter int MAX_SETS   = sact_pkg::MAX_SETS_D,
	parameter int LINE_BYTES = sact_pkg::LINE_BYTES_D,
	parameter int ADDR_WIDTH = sact_pkg::ADDR_WIDTH_D
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sact_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [sact_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                           req_valid,
	output logic                                req_ready,
	input  wire logic                           func,
	input  wire logic [ADDR_WIDTH-1:0]          address,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output logic                                hit,
	output logic                                memory_read,
	output logic                                memory_write,
	output logic [sact_pkg::CNT_W-1:0]           hit_total,
	output logic [sact_pkg::CNT_W-1:0]           miss_total,
	output logic [sact_pkg::CNT_W-1:0]           read_total,
	output logic [sact_pkg::CNT_W-1:0]           write_total
);
	import sact_pkg::*;

	localparam int OFF_W  = $clog2(LINE_BYTES);
	localparam int LINE_W = ADDR_WIDTH - OFF_W;
	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int LG_MAX = $clog2(MAX_SETS);
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int AGE_W  = WAY_W;
	localparam int WCNT_W = $clog2(MAX_WAYS + 1);
	localparam int TAG_W  = LINE_W;
	localparam logic [AGE_W-1:0] AGE_TOP = AGE_W'(MAX_WAYS - 1);
	// one row: per way valid, dirty, age, tag; then the fifo pointer
	localparam int WAY_BITS = 2 + AGE_W + TAG_W;
	localparam int ROW_W    = MAX_WAYS * WAY_BITS + WAY_W;

	// configuration registers
	logic [3:0] set_log2_q;
	logic [3:0] ways_q;
	logic       replace_q;
	logic       write_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_log2_q <= 4'd6;
			ways_q     <= 4'd8;
			replace_q  <= 1'b0;
			write_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_SET_LOG2: set_log2_q <= cfg_wdata;
				REG_WAYS:     ways_q     <= cfg_wdata;
				REG_REPLACE:  replace_q  <= cfg_wdata[0];
				REG_WRITE:    write_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// effective set count log2 and ways
	logic [3:0]        lg_eff;
	logic [WCNT_W-1:0] ways_eff;
	always_comb begin
		lg_eff = (32'(set_log2_q) > LG_MAX) ? 4'(LG_MAX) : set_log2_q;
		if (ways_q == 4'd0) begin
			ways_eff = WCNT_W'(1);
		end else if (32'(ways_q) > MAX_WAYS) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = WCNT_W'(ways_q);
		end
	end

	state_t state_q, state_d;
	logic [SET_W:0] clr_q;

	// request capture
	logic              func_s1;
	logic [SET_W-1:0]  set_s1;
	logic [TAG_W-1:0]  tag_s1;

	logic [LINE_W-1:0] line_in;
	logic [SET_W-1:0]  set_in;
	assign line_in = address[ADDR_WIDTH-1:OFF_W];
	always_comb begin
		set_in = '0;
		for (int b = 0; b < SET_W; b++) begin
			if (b < 32'(lg_eff)) begin
				set_in[b] = line_in[b];
			end
		end
	end

	logic             ram_we;
	logic [SET_W-1:0] ram_addr;
	logic [ROW_W-1:0] ram_wdata, ram_rdata;

	sact_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_row_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// row unpack
	logic [MAX_WAYS-1:0] v_r, d_r;
	logic [AGE_W-1:0]    a_r [MAX_WAYS];
	logic [TAG_W-1:0]    t_r [MAX_WAYS];
	logic [WAY_W-1:0]    p_r;
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			v_r[w] = ram_rdata[w*WAY_BITS];
			d_r[w] = ram_rdata[w*WAY_BITS+1];
			a_r[w] = ram_rdata[w*WAY_BITS+2 +: AGE_W];
			t_r[w] = ram_rdata[w*WAY_BITS+2+AGE_W +: TAG_W];
		end
		p_r = ram_rdata[MAX_WAYS*WAY_BITS +: WAY_W];
	end

	// lookup decision
	logic [MAX_WAYS-1:0] v_n, d_n;
	logic [AGE_W-1:0]    a_n [MAX_WAYS];
	logic [TAG_W-1:0]    t_n [MAX_WAYS];
	logic [WAY_W-1:0]    p_n;
	logic                found, have_free, was_valid, wb, lru, wr, wflag;
	logic [WAY_W-1:0]    hit_way, free_way, lru_way, fifo_way, victim;
	logic [AGE_W-1:0]    best, old_age;
	logic [1:0]          wr_inc;

	always_comb begin
		wb = write_q;
		lru = !replace_q;
		wr = func_s1;
		found = 1'b0;
		have_free = 1'b0;
		hit_way = '0;
		free_way = '0;
		lru_way = '0;
		best = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (w < 32'(ways_eff)) begin
				if (v_r[w] && t_r[w] == tag_s1) begin
					found = 1'b1;
					hit_way = WAY_W'(w);
				end
				if (!v_r[w]) begin
					have_free = 1'b1;
					free_way = WAY_W'(w);
				end
			end
		end
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < 32'(ways_eff) && (w == 0 || a_r[w] > best)) begin
				best = a_r[w];
				lru_way = WAY_W'(w);
			end
		end
		fifo_way = (32'(p_r) >= 32'(ways_eff)) ? '0 : p_r;
		v_n = v_r;
		d_n = d_r;
		a_n = a_r;
		t_n = t_r;
		p_n = p_r;
		wflag = 1'b0;
		wr_inc = 2'd0;
		if (found) begin
			victim = hit_way;
			was_valid = 1'b1;
			if (wr) begin
				if (wb) begin
					d_n[hit_way] = 1'b1;
				end else begin
					wflag = 1'b1;
					wr_inc = 2'd1;
				end
			end
		end else begin
			if (have_free) begin
				victim = free_way;
			end else if (lru) begin
				victim = lru_way;
			end else begin
				victim = fifo_way;
				p_n = (32'(fifo_way) + 1 < 32'(ways_eff)) ? WAY_W'(fifo_way + 1'b1) : '0;
			end
			was_valid = v_r[victim];
			if (was_valid && d_r[victim]) begin
				wflag = 1'b1;
				wr_inc = wr_inc + 2'd1;
			end
			v_n[victim] = 1'b1;
			t_n[victim] = tag_s1;
			d_n[victim] = wr && wb;
			if (wr && !wb) begin
				wflag = 1'b1;
				wr_inc = wr_inc + 2'd1;
			end
		end
		old_age = a_r[victim];
		if (lru) begin
			for (int w = 0; w < MAX_WAYS; w++) begin
				if (w < 32'(ways_eff) && WAY_W'(w) != victim && v_r[w] &&
						(!was_valid || a_r[w] < old_age) && a_r[w] < AGE_TOP) begin
					a_n[w] = a_r[w] + 1'b1;
				end
			end
			a_n[victim] = '0;
		end
	end

	// row pack
	logic [ROW_W-1:0] row_new;
	always_comb begin
		row_new = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			row_new[w*WAY_BITS]                  = v_n[w];
			row_new[w*WAY_BITS+1]                = d_n[w];
			row_new[w*WAY_BITS+2 +: AGE_W]       = a_n[w];
			row_new[w*WAY_BITS+2+AGE_W +: TAG_W] = t_n[w];
		end
		row_new[MAX_WAYS*WAY_BITS +: WAY_W] = p_n;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (32'(clr_q) == MAX_SETS - 1) state_d = ST_IDLE;
			ST_IDLE:   if (req_valid) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_OUT;
			ST_OUT:    if (rsp_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		req_ready = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = set_in;
		ram_wdata = row_new;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q[SET_W-1:0];
				ram_wdata = '0;
			end
			ST_IDLE:   req_ready = 1'b1;
			ST_LOOKUP: begin
				ram_we   = 1'b1;
				ram_addr = set_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			func_s1 <= func;
			set_s1  <= set_in;
			tag_s1  <= line_in >> lg_eff;
		end
	end

	// result and totals
	logic hit_q, rd_q, wr_q;
	logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, rd_cnt_q, wr_cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			rd_cnt_q   <= '0;
			wr_cnt_q   <= '0;
			hit_q      <= 1'b0;
			rd_q       <= 1'b0;
			wr_q       <= 1'b0;
		end else if (state_q == ST_LOOKUP) begin
			hit_q <= found;
			rd_q  <= !found;
			wr_q  <= wflag;
			if (found) begin
				hit_cnt_q <= hit_cnt_q + 1'b1;
			end else begin
				miss_cnt_q <= miss_cnt_q + 1'b1;
				rd_cnt_q   <= rd_cnt_q + 1'b1;
			end
			wr_cnt_q <= wr_cnt_q + CNT_W'(wr_inc);
		end
	end

	assign rsp_valid    = (state_q == ST_OUT);
	assign hit          = hit_q;
	assign memory_read  = rd_q;
	assign memory_write = wr_q;
	assign hit_total    = hit_cnt_q;
	assign miss_total   = miss_cnt_q;
	assign read_total   = rd_cnt_q;
	assign write_total  = wr_cnt_q;

	`SACT_ASSERT_IMP(a_excl, clk, arst_n, rsp_valid, !req_ready, "request taken during result")
	`SACT_ASSERT_IMP(a_hitmiss, clk, arst_n, rsp_valid, hit != memory_read, "hit and fetch disagree")
	`SACT_ASSERT_NXT(a_lookup, clk, arst_n, req_valid && req_ready, state_q == ST_LOOKUP, "no lookup")
	`SACT_ASSERT_NXT(a_cnt, clk, arst_n, state_q == ST_LOOKUP, hit_total + miss_total == $past(hit_total + miss_total) + 1, "count step")
endmodule
`default_nettype wire

/* sim/set_assoc_cache_tag_controller_unit_tb.sv */
`timescale 1ns / 1ps
// testbench of the set-associative cache tag controller: random and directed accesses
// under several geometries and policies, checked against a cycle-free tag store predictor
// depends on sact_pkg, sact_if and set_assoc_cache_tag_controller_unit
module set_assoc_cache_tag_controller_unit_tb;
	import sact_pkg::*;

	localparam int TAG_W = ADDR_WIDTH_D - 6;

	typedef struct packed {
		logic                    func;
		logic [ADDR_WIDTH_D-1:0] address;
	} access_t;

	typedef struct packed {
		logic             hit;
		logic             memory_read;
		logic             memory_write;
		logic [CNT_W-1:0] hit_total;
		logic [CNT_W-1:0] miss_total;
		logic [CNT_W-1:0] read_total;
		logic [CNT_W-1:0] write_total;
	} outcome_t;

	// tag store predictor plus the queue of outcomes still owed by the block
	class cache_scoreboard;
		bit [TAG_W-1:0] tags[MAX_SETS_D][MAX_WAYS_D];
		bit             valid[MAX_SETS_D][MAX_WAYS_D];
		bit             dirty[MAX_SETS_D][MAX_WAYS_D];
		bit [2:0]       age[MAX_SETS_D][MAX_WAYS_D];
		bit [2:0]       fifo_ptr[MAX_SETS_D];
		bit [31:0]      hits, misses, reads, writes;
		bit [3:0]       set_log2 = 6, ways_cfg = 8;
		bit             fifo_mode = 0, write_back = 1;
		outcome_t       owed[$];
		int             errors = 0;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_SET_LOG2: set_log2 = val;
				REG_WAYS:     ways_cfg = val;
				REG_REPLACE:  fifo_mode = val[0];
				REG_WRITE:    write_back = val[0];
				default: ;
			endcase
		endfunction

		function void age_touch(int set, int ways, int way, bit was_valid);
			bit [2:0] old;
			old = age[set][way];
			for (int i = 0; i < ways; i++) begin
				if (i == way || !valid[set][i]) continue;
				if ((!was_valid || age[set][i] < old) && age[set][i] < MAX_WAYS_D - 1)
					age[set][i]++;
			end
			age[set][way] = 0;
		endfunction

		function void note_access(access_t a);
			int             lg, ways, set, way;
			bit [TAG_W-1:0] line, tag;
			bit             found, was_valid;
			outcome_t       o;
			lg = (set_log2 > 10) ? 10 : set_log2;
			ways = (ways_cfg < 1) ? 1 : ((ways_cfg > MAX_WAYS_D) ? MAX_WAYS_D : ways_cfg);
			line = a.address[ADDR_WIDTH_D-1:6];
			set = int'(line & ((42'd1 << lg) - 1));
			tag = line >> lg;
			o = '0;
			found = 0;
			way = 0;
			for (int i = 0; i < ways; i++)
				if (!found && valid[set][i] && tags[set][i] == tag) begin
					found = 1;
					way = i;
				end
			if (found) begin
				o.hit = 1;
				hits++;
				if (a.func) begin
					if (write_back) dirty[set][way] = 1;
					else begin
						writes++;
						o.memory_write = 1;
					end
				end
				if (!fifo_mode) age_touch(set, ways, way, 1);
			end else begin
				misses++;
				for (int i = ways - 1; i >= 0; i--)
					if (!valid[set][i]) begin
						found = 1;
						way = i;
					end
				if (!found) begin
					if (!fifo_mode) begin
						way = 0;
						for (int i = 1; i < ways; i++)
							if (age[set][i] > age[set][way]) way = i;
					end else begin
						way = (fifo_ptr[set] >= ways) ? 0 : int'(fifo_ptr[set]);
						fifo_ptr[set] = 3'((way + 1 < ways) ? way + 1 : 0);
					end
				end
				was_valid = valid[set][way];
				if (was_valid && dirty[set][way]) begin
					writes++;
					o.memory_write = 1;
				end
				valid[set][way] = 1;
				tags[set][way] = tag;
				dirty[set][way] = a.func && write_back;
				reads++;
				o.memory_read = 1;
				if (a.func && !write_back) begin
					writes++;
					o.memory_write = 1;
				end
				if (!fifo_mode) age_touch(set, ways, way, was_valid);
			end
			o.hit_total = hits;
			o.miss_total = misses;
			o.read_total = reads;
			o.write_total = writes;
			owed.push_back(o);
		endfunction

		function void check_outcome(outcome_t got);
			outcome_t want;
			if (owed.size() == 0) begin
				$error("outcome with no request outstanding");
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0d, actual %0d", want.hit, got.hit);
				errors++;
			end
			if (got.memory_read !== want.memory_read) begin
				$error("memory_read: expected %0d, actual %0d", want.memory_read, got.memory_read);
				errors++;
			end
			if (got.memory_write !== want.memory_write) begin
				$error("memory_write: expected %0d, actual %0d", want.memory_write,
					got.memory_write);
				errors++;
			end
			if (got.hit_total !== want.hit_total) begin
				$error("hit_total: expected %0d, actual %0d", want.hit_total, got.hit_total);
				errors++;
			end
			if (got.miss_total !== want.miss_total) begin
				$error("miss_total: expected %0d, actual %0d", want.miss_total, got.miss_total);
				errors++;
			end
			if (got.read_total !== want.read_total) begin
				$error("read_total: expected %0d, actual %0d", want.read_total, got.read_total);
				errors++;
			end
			if (got.write_total !== want.write_total) begin
				$error("write_total: expected %0d, actual %0d", want.write_total,
					got.write_total);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  cfg_we = 0;
	logic [CFG_IDX_W-1:0]  cfg_idx = REG_SET_LOG2;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	bit                    quiet = 0;   // no idling on either side near the end
	int                    stall_left = 0;

	sact_if #(.payload_t(access_t))  req_ch ();
	sact_if #(.payload_t(outcome_t)) rsp_ch ();

	cache_scoreboard sb = new();

	initial begin
		req_ch.valid = 0;
		req_ch.data = '0;
		rsp_ch.ready = 0;
	end

	always #4 clk = ~clk;

	set_assoc_cache_tag_controller_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.req_valid    (req_ch.valid),
		.req_ready    (req_ch.ready),
		.func         (req_ch.data.func),
		.address      (req_ch.data.address),
		.rsp_valid    (rsp_ch.valid),
		.rsp_ready    (rsp_ch.ready),
		.hit          (rsp_ch.data.hit),
		.memory_read  (rsp_ch.data.memory_read),
		.memory_write (rsp_ch.data.memory_write),
		.hit_total    (rsp_ch.data.hit_total),
		.miss_total   (rsp_ch.data.miss_total),
		.read_total   (rsp_ch.data.read_total),
		.write_total  (rsp_ch.data.write_total)
	);

	// sampling in the active region of the edge sees the values before any update
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_outcome(rsp_ch.data);
		// receiver stalls in random bursts
		if (quiet) begin
			rsp_ch.ready <= 1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 17);
			rsp_ch.ready <= 0;
		end else begin
			rsp_ch.ready <= 1;
		end
	end

	// called at a rising edge; returns at the edge where the request was taken
	task automatic send_access(bit wr, logic [ADDR_WIDTH_D-1:0] addr);
		access_t a;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		a.func = wr;
		a.address = addr;
		req_ch.valid <= 1;
		req_ch.data <= a;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_access(a);
	endtask

	// lets the block drain and settle after the last outcome
	task automatic drain();
		req_ch.valid <= 0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_reg(idx, val);
	endtask

	// address from a small pool of tags over a few sets, so hits and evictions are common
	function automatic logic [ADDR_WIDTH_D-1:0] pick_addr(ref logic [ADDR_WIDTH_D-1:0] pool[8]);
		logic [ADDR_WIDTH_D-1:0] a;
		int                      r;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			a = ADDR_WIDTH_D'({$urandom, $urandom});  // noise anywhere in the address space
		end else begin
			a = pool[$urandom_range(0, 7)];
			// spread over a handful of sets near the bottom of the index field
			a[8:6] = 3'($urandom_range(0, 3));
			a[5:0] = 6'($urandom);
		end
		return a;
	endfunction

	task automatic random_phase(int n, int pressure_at);
		logic [ADDR_WIDTH_D-1:0] pool[8];
		for (int i = 0; i < 8; i++) pool[i] = ADDR_WIDTH_D'({$urandom, $urandom});
		for (int i = 0; i < n; i++) begin
			if (i == pressure_at) begin
				// hold off until every outcome is back
				req_ch.valid <= 0;
				@(posedge clk);
				while (sb.owed.size() != 0) @(posedge clk);
			end
			send_access(1'($urandom_range(0, 1)), pick_addr(pool));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: cold miss, read hit, write hit, all-ones address
		send_access(0, '0);
		send_access(0, 48'h3f);
		send_access(1, 48'h20);
		send_access(1, '1);
		send_access(0, '1);
		// nine tags into set 0 of 8 ways after line 0: all dirty, the last two evict the oldest
		for (int t = 1; t <= 9; t++) send_access(1, 48'(t) << 12);
		send_access(0, 48'h1000);   // refetch the evicted dirty line
		send_access(0, 48'h2000);
		send_access(1, 48'h5555_5555_5540);
		send_access(1, 48'haaaa_aaaa_aa80);
		drain();

		// write-through with dirty lines still in the store, FIFO, a single set and way
		write_reg(REG_WRITE, 0);
		send_access(0, 48'h3000);   // evicts a dirty line while writing through
		send_access(1, 48'h4000);
		drain();
		write_reg(REG_REPLACE, 1);
		random_phase(120, 40);
		drain();
		write_reg(REG_SET_LOG2, 0);
		write_reg(REG_WAYS, 1);
		random_phase(150, -1);
		drain();

		// largest set count, zero ways acts as one, then out-of-range values
		write_reg(REG_SET_LOG2, 10);
		write_reg(REG_WAYS, 0);
		write_reg(REG_REPLACE, 0);
		write_reg(REG_WRITE, 1);
		random_phase(150, -1);
		drain();
		write_reg(REG_SET_LOG2, 15);
		write_reg(REG_WAYS, 15);
		random_phase(150, -1);
		drain();
		write_reg(REG_SET_LOG2, 2);
		write_reg(REG_WAYS, 3);
		write_reg(REG_REPLACE, 1);
		random_phase(150, -1);
		drain();
		write_reg(REG_WRITE, 0);
		write_reg(REG_WAYS, 8);
		random_phase(150, -1);
		drain();
		write_reg(REG_SET_LOG2, 1);
		write_reg(REG_WAYS, 5);
		write_reg(REG_REPLACE, 0);
		write_reg(REG_WRITE, 1);
		random_phase(150, -1);
		// last stretch with no idling on either side
		quiet = 1;
		random_phase(110, -1);
		drain();

		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("** set_assoc_cache_tag_controller_unit: PASSED **");
		else
			$display("** set_assoc_cache_tag_controller_unit: FAILED **");
		$finish;
	end

	initial begin
		#5ms;
		$display("** set_assoc_cache_tag_controller_unit: FAILED **");
		$finish;
	end
endmodule
